@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared assertion forms for the checker files, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg
// widths, register codes and shared types of the nearest prototype encoder
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int PROTO_COUNT = 64;
  localparam int VALUE_BITS  = 16;

  localparam int IDX_W    = $clog2(PROTO_COUNT);
  localparam int RANK_W   = $clog2(PROTO_COUNT + 1);
  localparam int ENTRY_W  = 6;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;
  localparam int CODE_W   = 64;
  localparam int REG_IDX_W = 2;

  localparam logic [CFG_W-1:0] ACTIVE_BITS_RST = CFG_W'(8);
  localparam logic [CFG_W-1:0] SIZE_IN_USE_RST = CFG_W'(64);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACTIVE_BITS = 2'd0,
    REG_SIZE_IN_USE = 2'd1
  } reg_idx_t;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ENCODE = 1'b1
  } func_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic start;
    logic step;
  } nps_ctrl_t;

  // distance token handed from cell to cell
  typedef struct packed {
    logic [VALUE_BITS-1:0] span;
    logic [IDX_W-1:0]      idx;
  } nps_trav_t;

  function automatic logic [VALUE_BITS-1:0] sample_to_value(
    input logic [SAMPLE_W-1:0] s
  );
    logic [31:0] ext;
    ext = 32'(s);
    return ext[VALUE_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/nearest_prototype_sdr_encoder.sv @@
// ----------------------------------------------------------------------------
// nearest_prototype_sdr_encoder
// sparse scalar code from the prototypes nearest to the scalar
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   in_     | in_valid / in_stall | in_func, in_entry_index, in_sample_value
//   out_    | out_valid/out_stall | out_code_bits
//   cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load does not stall the input; an encode holds the input stalled while the
// cells form the distances, the token ring passes through the whole cell row
// and the output register is filled (longer if that beat is stalled)
// reset (rst_n low, synchronous) clears the sequencer and the registers;
// prototype entries hold garbage until loaded
// loads and new encodes are taken while an earlier result waits on out_stall
// ----------------------------------------------------------------------------
module nearest_prototype_sdr_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [nps_pkg::ENTRY_W-1:0]      in_entry_index,
  input  logic [nps_pkg::SAMPLE_W-1:0]     in_sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nps_pkg::CODE_W-1:0]       out_code_bits,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nps_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [nps_pkg::CFG_W-1:0]        cfg_data
);
  import nps_pkg::*;

  logic [CFG_W-1:0]       act_limit_r;
  logic [CFG_W-1:0]       size_in_use_r;
  logic [VALUE_BITS-1:0]  value;
  logic [PROTO_COUNT-1:0] sel_vec;
  nps_trav_t              trav [PROTO_COUNT];
  nps_ctrl_t              ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_limit_r   <= ACTIVE_BITS_RST;
      size_in_use_r <= SIZE_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_BITS: act_limit_r <= cfg_data;
        REG_SIZE_IN_USE: size_in_use_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign value = sample_to_value(in_sample_value);

  // cells form a ring, each takes the token of the cell below it
  for (genvar k = 0; k < PROTO_COUNT; k++) begin : g_cell
    nps_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(k)),
      .ctrl        (ctrl),
      .load_idx    (in_entry_index),
      .value       (value),
      .act_limit   (act_limit_r),
      .size_in_use (size_in_use_r),
      .trav_in     (trav[(k + PROTO_COUNT - 1) % PROTO_COUNT]),
      .trav_out    (trav[k]),
      .sel         (sel_vec[k])
    );
  end

  nps_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_func       (in_func),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_bits (out_code_bits),
    .code_vec      (CODE_W'(sel_vec)),
    .ctrl          (ctrl)
  );

endmodule

@@ rtl/core/nps_cell.sv @@
// ----------------------------------------------------------------------------
// nps_cell
// one prototype entry: holds its value, its distance to the scalar and a
// rank counter, and passes a distance token on to the next cell
// ----------------------------------------------------------------------------
module nps_cell (
  input  logic                         clk,
  input  logic [nps_pkg::IDX_W-1:0]    cell_idx,
  input  nps_pkg::nps_ctrl_t           ctrl,
  input  logic [nps_pkg::ENTRY_W-1:0]  load_idx,
  input  logic [nps_pkg::VALUE_BITS-1:0] value,
  input  logic [nps_pkg::CFG_W-1:0]    act_limit,
  input  logic [nps_pkg::CFG_W-1:0]    size_in_use,
  input  nps_pkg::nps_trav_t           trav_in,
  output nps_pkg::nps_trav_t           trav_out,
  output logic                         sel
);
  import nps_pkg::*;

  logic [VALUE_BITS-1:0] proto_r;
  logic [VALUE_BITS-1:0] dist_r;
  logic [VALUE_BITS-1:0] dist_nxt;
  logic [RANK_W-1:0]     rank_r;
  nps_trav_t             trav_r;
  logic                  hit;

  assign dist_nxt = (proto_r >= value) ? (proto_r - value) : (value - proto_r);

  // token is nearer, or equally near with a lower index, and within size
  assign hit = (CFG_W'(trav_r.idx) < size_in_use) &&
               ((trav_r.span < dist_r) ||
                ((trav_r.span == dist_r) && (trav_r.idx < cell_idx)));

  always_ff @(posedge clk) begin
    if (ctrl.load && (load_idx == ENTRY_W'(cell_idx))) begin
      proto_r <= value;
    end
    if (ctrl.start) begin
      dist_r      <= dist_nxt;
      trav_r.span <= dist_nxt;
      trav_r.idx  <= cell_idx;
      rank_r      <= '0;
    end else if (ctrl.step) begin
      trav_r <= trav_in;
      if (hit) begin
        rank_r <= rank_r + RANK_W'(1);
      end
    end
  end

  assign trav_out = trav_r;
  assign sel      = (CFG_W'(cell_idx) < size_in_use) && (CFG_W'(rank_r) < act_limit);

endmodule

@@ rtl/core/nps_ctrl.sv @@
// ----------------------------------------------------------------------------
// nps_ctrl
// sequencer: starts the cell row, counts the token passes and holds the
// result beat in the output register
// ----------------------------------------------------------------------------
module nps_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_func,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nps_pkg::CODE_W-1:0]  out_code_bits,
  input  logic [nps_pkg::CODE_W-1:0]  code_vec,
  output nps_pkg::nps_ctrl_t          ctrl
);
  import nps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r;
  logic               in_acc;
  logic               capture;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign ctrl.load  = in_acc && (in_func == FUNC_LOAD);
  assign ctrl.start = in_acc && (in_func == FUNC_ENCODE);
  assign ctrl.step  = (state_r == ST_RUN);

  // output register free or being emptied this cycle
  assign capture = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(PROTO_COUNT - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (capture) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (capture) begin
        out_code_r <= code_vec;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_bits = out_code_r;

endmodule

@@ rtl/core/nps_checker.sv @@
// ----------------------------------------------------------------------------
// nps_checker
// port level checks of the encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_func,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [nps_pkg::CODE_W-1:0]      out_code_bits
);
  import nps_pkg::*;

  logic enc_acc;
  logic load_acc;

  assign enc_acc  = in_valid && !in_stall && (in_func == FUNC_ENCODE);
  assign load_acc = in_valid && !in_stall && (in_func == FUNC_LOAD);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_code_bits), "stalled code moved")
  `ASSERT_NEXT(a_enc_busy, enc_acc, in_stall && !$rose(out_valid), "encode not held busy")
  `ASSERT_NEXT(a_load_free, load_acc, !in_stall, "load blocked the input")

endmodule

bind nearest_prototype_sdr_encoder nps_checker u_nps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_code_bits (out_code_bits)
);

@@ dv/tb_nearest_prototype_sdr_encoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_prototype_sdr_encoder
// Self-checking bench for the nearest prototype sparse scalar encoder. Tasks
// load prototype entries and send scalars through the valid/stall input. A
// code tracker keeps its own copy of the prototype table and the registers.
// For each accepted encode it forms the expected sparse code. Result beats
// are matched in order against those codes. The input side runs in random
// bursts. The output side stalls in changing patterns, with one long hold.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_nearest_prototype_sdr_encoder;
  import nps_pkg::*;

  localparam int SETTLE_CYCLES = PROTO_COUNT + 8;
  localparam int PHASE_ITEMS   = 46;
  localparam int PHASE_COUNT   = 8;
  localparam int LONG_HOLD     = 400;
  // register index past the defined list, writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // keeps a shadow of the prototype table and predicts each code
  class sdr_code_tracker;
    logic [VALUE_BITS-1:0] proto_vals [PROTO_COUNT];
    logic [PROTO_COUNT-1:0] written;
    logic [CFG_W-1:0] act_limit;
    logic [CFG_W-1:0] size_in_use;
    logic [CODE_W-1:0] pending_codes [$];
    int mismatches;

    function new();
      written = '0;
      act_limit = ACTIVE_BITS_RST;
      size_in_use = SIZE_IN_USE_RST;
      mismatches = 0;
    endfunction

    function int entries_in_use();
      return (size_in_use > PROTO_COUNT) ? PROTO_COUNT : int'(size_in_use);
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ACTIVE_BITS) begin
        act_limit = data;
      end else if (idx == REG_SIZE_IN_USE) begin
        size_in_use = data;
      end
    endfunction

    // rank every entry in use by distance, lower index wins a tie
    function logic [CODE_W-1:0] nearest_code(logic [VALUE_BITS-1:0] scalar);
      logic [VALUE_BITS-1:0] span [PROTO_COUNT];
      logic [CODE_W-1:0] code;
      int n;
      int rank;
      n = entries_in_use();
      code = '0;
      for (int i = 0; i < n; i++) begin
        span[i] = (proto_vals[i] >= scalar) ? proto_vals[i] - scalar : scalar - proto_vals[i];
      end
      for (int i = 0; i < n; i++) begin
        rank = 0;
        for (int j = 0; j < n; j++) begin
          if (span[j] < span[i] || (span[j] == span[i] && j < i)) rank++;
        end
        if (rank < int'(act_limit)) code[i] = 1'b1;
      end
      return code;
    endfunction

    function void take_item(func_t f, logic [ENTRY_W-1:0] idx, logic [SAMPLE_W-1:0] sample);
      if (f == FUNC_LOAD) begin
        proto_vals[idx] = sample[VALUE_BITS-1:0];
        written[idx] = 1'b1;
      end else begin
        pending_codes = {pending_codes, nearest_code(sample[VALUE_BITS-1:0])};
      end
    endfunction

    function void match_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      if (pending_codes.size() == 0) begin
        $error("code_bits: beat with no code pending, actual %h", got);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          $error("code_bits mismatch: expected %h, actual %h", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = 1'b0;
  logic [ENTRY_W-1:0]   in_entry_index = '0;
  logic [SAMPLE_W-1:0]  in_sample_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    out_code_bits;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sdr_code_tracker tracker = new();
  bit hold_request = 1'b0;
  logic [VALUE_BITS-1:0] cluster_center = '0;

  nearest_prototype_sdr_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_bits   (out_code_bits),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send(func_t f, logic [ENTRY_W-1:0] idx, logic [SAMPLE_W-1:0] sample);
    in_valid        <= 1'b1;
    in_func         <= f;
    in_entry_index  <= idx;
    in_sample_value <= sample;
    do @(posedge clk); while (in_stall);
    tracker.take_item(f, idx, sample);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every pending code, then let a trailing load finish
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // prototype values: wide random, a tight cluster, or a copy of an entry
  function automatic logic [SAMPLE_W-1:0] proto_value();
    int pick;
    pick = $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      2: return cluster_center + SAMPLE_W'($urandom_range(0, 31));
      3: return tracker.written[pick] ? tracker.proto_vals[pick] : SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // output side: checks beats and stalls on a pattern of its own
  initial begin : result_side
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    bit hold_used;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.match_code(out_code_bits);
      cyc++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 250);
      end
      mode_left--;
      if (hold_request && !hold_used) begin
        hold_left = LONG_HOLD;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ((cyc % 23) < 9);
        endcase
      end
    end
  end

  initial begin : stimulus
    int setting_act [6];
    int setting_sz  [6];
    int act;
    int sz;
    int n;
    int left;
    int burst;
    int gap;
    logic [SAMPLE_W-1:0] scalar;

    setting_act = '{8, 1, 64, 127, 3, 0};
    setting_sz  = '{64, 127, 64, 20, 1, 64};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, duplicate entries for ties, top entry index
    write_reg(REG_ACTIVE_BITS, 7'd2);
    write_reg(REG_SIZE_IN_USE, 7'd4);
    send(FUNC_LOAD, 6'd0, 16'h0000);
    send(FUNC_LOAD, 6'd1, 16'hFFFF);
    send(FUNC_LOAD, 6'd2, 16'h8000);
    send(FUNC_LOAD, 6'd3, 16'h8000);
    send(FUNC_LOAD, 6'd63, 16'hFFFF);
    send(FUNC_ENCODE, 6'd0, 16'h0000);
    send(FUNC_ENCODE, 6'h3F, 16'hFFFF);
    send(FUNC_ENCODE, 6'd0, 16'h8000);
    send(FUNC_ENCODE, 6'd0, 16'h4000);
    send(FUNC_ENCODE, 6'd0, 16'hC000);
    settle();
    // no active bits gives an empty code
    write_reg(REG_ACTIVE_BITS, 7'd0);
    send(FUNC_ENCODE, 6'd0, 16'h1234);
    settle();
    // active bits beyond the size saturate
    write_reg(REG_ACTIVE_BITS, 7'h7F);
    send(FUNC_ENCODE, 6'd0, 16'h9000);
    settle();
    write_reg(REG_SIZE_IN_USE, 7'd0);
    send(FUNC_ENCODE, 6'd0, 16'hABCD);
    settle();
    // a write past the register list must leave both registers alone
    write_reg(REG_SPARE, 7'h7F);
    write_reg(REG_SIZE_IN_USE, 7'd4);
    send(FUNC_ENCODE, 6'd0, 16'h0001);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 6) begin
        act = setting_act[p];
        sz = setting_sz[p];
      end else begin
        act = $urandom_range(1, 64);
        sz = $urandom_range(1, 64);
      end
      write_reg(REG_ACTIVE_BITS, CFG_W'(act));
      write_reg(REG_SIZE_IN_USE, CFG_W'(sz));
      cluster_center = VALUE_BITS'($urandom);
      n = tracker.entries_in_use();
      // every entry in use gets loaded before it is encoded against
      for (int i = 0; i < n; i++) begin
        if (!tracker.written[i]) send(FUNC_LOAD, ENTRY_W'(i), proto_value());
      end
      if (p == 2) hold_request = 1'b1;

      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && left > 0; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            send(FUNC_LOAD, ENTRY_W'($urandom_range(0, 63)), proto_value());
          end else begin
            case ($urandom_range(0, 4))
              2: scalar = ($urandom_range(0, 1) == 1) ? '1 : '0;
              3, 4: scalar = (n > 0)
                ? tracker.proto_vals[$urandom_range(0, n - 1)] + SAMPLE_W'($urandom_range(0, 64))
                  - SAMPLE_W'(32)
                : SAMPLE_W'($urandom);
              default: scalar = SAMPLE_W'($urandom);
            endcase
            send(FUNC_ENCODE, ENTRY_W'($urandom), scalar);
          end
          left--;
        end
        case ($urandom_range(0, 5))
          0: gap = 0;
          1: gap = $urandom_range(40, 90);
          default: gap = $urandom_range(1, 8);
        endcase
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      settle();
    end

    if (tracker.mismatches == 0 && tracker.pending_codes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
